// ----- hdl/kscu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kscu_pkg
// Shared constants and controller/datapath interface types for the k-subset
// unranking block.
// ----------------------------------------------------------------------------
package kscu_pkg;

  localparam int MAX_ELEMENT = 64;
  localparam int MAX_SUBSET  = 16;

  localparam int SIZE_W = 5;
  localparam int RANK_W = 49;
  localparam int POS_W  = 4;
  localparam int ELEM_W = 7;
  localparam int COEF_W = 56;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  localparam int DIV_DIGIT = 8;
  localparam int DIV_STEPS = COEF_W / DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;
    logic pinit;
    logic mul;
    logic div_start;
    logic coef_load;
    logic emit;
    logic emit_eerr;
    logic emit_serr;
  } kscu_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_over;
    logic elem_over;
    logic found;
    logic div_busy;
    logic out_free;
    logic last_pos;
  } kscu_stat_t;

endpackage
`default_nettype wire

// ----- hdl/kscu_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kscu_div
// Radix-256 restoring divider: wide dividend by a narrow divisor, one byte
// of quotient per cycle, quotient held in place when done.
// ----------------------------------------------------------------------------
module kscu_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [kscu_pkg::COEF_W-1:0]  dividend,
  input  wire logic [kscu_pkg::ELEM_W-1:0]  divisor,
  output logic                              busy,
  output logic [kscu_pkg::COEF_W-1:0]       quotient
);

  logic                               busy_r;
  logic [kscu_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [kscu_pkg::COEF_W-1:0]        work_r;
  logic [kscu_pkg::ELEM_W-2:0]        rem_r;
  logic [kscu_pkg::ELEM_W-1:0]        dsr_r;
  logic [kscu_pkg::ELEM_W-2:0]        rem_nxt;
  logic [kscu_pkg::DIV_DIGIT-1:0]     qbits;

  always_comb begin
    logic [kscu_pkg::ELEM_W-1:0] part;
    logic [kscu_pkg::ELEM_W-2:0] rem_v;
    rem_v = rem_r;
    qbits = '0;
    for (int j = 0; j < kscu_pkg::DIV_DIGIT; j++) begin
      part = {rem_v, work_r[kscu_pkg::COEF_W-1-j]};
      if (part >= dsr_r) begin
        part = part - dsr_r;
        qbits[kscu_pkg::DIV_DIGIT-1-j] = 1'b1;
      end
      rem_v = part[kscu_pkg::ELEM_W-2:0];
    end
    rem_nxt = rem_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == kscu_pkg::DIV_CNT_W'(kscu_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      work_r <= {work_r[kscu_pkg::COEF_W-kscu_pkg::DIV_DIGIT-1:0], qbits};
      rem_r  <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = work_r;

endmodule
`default_nettype wire

// ----- hdl/kscu_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kscu_dpath
// Datapath: remaining rank, position, candidate element, binomial
// coefficient, multiplier stage, divider and the result register.
// ----------------------------------------------------------------------------
module kscu_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire kscu_pkg::kscu_cmd_t               cmd,
  output kscu_pkg::kscu_stat_t                   stat,
  input  wire logic [kscu_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kscu_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tuser
);

  logic [kscu_pkg::SIZE_W-1:0]             in_size;
  logic [kscu_pkg::RANK_W-1:0]             in_rank;

  logic [kscu_pkg::SIZE_W-1:0]             pos_r;
  logic [kscu_pkg::RANK_W-1:0]             rem_r;
  logic [kscu_pkg::ELEM_W-1:0]             elem_r;
  logic [kscu_pkg::COEF_W-1:0]             coef_r;
  logic [kscu_pkg::RANK_W-1:0]             prev_r;
  logic [kscu_pkg::COEF_W-1:0]             prod_r;

  logic                                    out_valid_r;
  logic [kscu_pkg::POS_W-1:0]              out_pos_r;
  logic [kscu_pkg::ELEM_W-1:0]             out_elem_r;
  logic                                    out_last_r;
  logic                                    out_err_r;

  logic [kscu_pkg::ELEM_W-1:0]             elem_inc;
  logic [kscu_pkg::RANK_W+kscu_pkg::ELEM_W-1:0] mul_w;
  logic [kscu_pkg::SIZE_W-1:0]             pos_dec;
  logic [kscu_pkg::ELEM_W-1:0]             div_dsr;
  logic [kscu_pkg::COEF_W-1:0]             div_quot;
  logic                                    div_busy;
  logic                                    out_free;

  assign in_size  = in_tdata[kscu_pkg::SIZE_W-1:0];
  assign in_rank  = in_tdata[kscu_pkg::SIZE_W +: kscu_pkg::RANK_W];

  assign elem_inc = elem_r + 1'b1;
  assign mul_w    = coef_r[kscu_pkg::RANK_W-1:0] * elem_inc;
  assign pos_dec  = pos_r - 1'b1;
  assign div_dsr  = elem_r - kscu_pkg::ELEM_W'(pos_r);
  assign out_free = !out_valid_r || out_tready;

  kscu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= (in_rank == '0) ? '0 : in_rank - 1'b1;
      pos_r <= in_size;
    end else if (cmd.emit) begin
      rem_r <= rem_r - prev_r;
      pos_r <= pos_dec;
    end

    if (cmd.pinit) begin
      elem_r <= kscu_pkg::ELEM_W'(pos_r);
      coef_r <= kscu_pkg::COEF_W'(1);
      prev_r <= '0;
    end else if (cmd.mul) begin
      elem_r <= elem_inc;
      prev_r <= coef_r[kscu_pkg::RANK_W-1:0];
      prod_r <= kscu_pkg::COEF_W'(mul_w);
    end else if (cmd.coef_load) begin
      coef_r <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_eerr || cmd.emit_serr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos_r  <= kscu_pkg::POS_W'(pos_dec);
      out_elem_r <= elem_r;
      out_last_r <= (pos_r == kscu_pkg::SIZE_W'(1));
      out_err_r  <= 1'b0;
    end else if (cmd.emit_eerr) begin
      out_pos_r  <= kscu_pkg::POS_W'(pos_dec);
      out_elem_r <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (cmd.emit_serr) begin
      out_pos_r  <= '0;
      out_elem_r <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign stat.k_zero    = (in_size == '0);
  assign stat.k_over    = (in_size > kscu_pkg::SIZE_W'(kscu_pkg::MAX_SUBSET));
  assign stat.elem_over = (elem_r > kscu_pkg::ELEM_W'(kscu_pkg::MAX_ELEMENT));
  assign stat.found     = (kscu_pkg::COEF_W'(rem_r) < coef_r);
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = out_free;
  assign stat.last_pos  = (pos_r == kscu_pkg::SIZE_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = kscu_pkg::OUT_TDATA_W'({out_elem_r, out_pos_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire

// ----- hdl/kscu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kscu_ctrl
// Controller: walks positions from k down to 1, steps candidates through
// compare, multiply and divide, and issues results.
// ----------------------------------------------------------------------------
module kscu_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire kscu_pkg::kscu_stat_t  stat,
  output kscu_pkg::kscu_cmd_t        cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PINIT = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DIVL  = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_EMIT  = 9'b001000000,
    ST_EERR  = 9'b010000000,
    ST_SERR  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          priority if (stat.k_zero) begin
            state_nxt = ST_IDLE;
          end else if (stat.k_over) begin
            state_nxt = ST_SERR;
          end else begin
            state_nxt = ST_PINIT;
          end
        end
      end
      ST_PINIT: begin
        cmd.pinit = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (stat.elem_over) begin
          state_nxt = ST_EERR;
        end else if (stat.found) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          cmd.coef_load = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last_pos ? ST_IDLE : ST_PINIT;
        end
      end
      ST_EERR: begin
        if (stat.out_free) begin
          cmd.emit_eerr = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SERR: begin
        if (stat.out_free) begin
          cmd.emit_serr = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

// ----- hdl/k_subset_unrank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_subset_unrank
// Colex unranking of k-subsets: one request (k, rank) in, up to k elements
// out, largest position first, with an error result on overflow.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)               | tlast | tuser
//  in_     | in  | subset_size[4:0], rank[53:5]     | -     | -
//  out_    | out | position[3:0], element_value[10:4] | last | error
//
//  One request at a time. Each candidate element passed over goes through
//  compare, 49x7 multiply, divider start, 7 radix-256 divide steps and
//  quotient load; each position adds init, final compare and emit. A request
//  holds the input until the controller has returned to idle.
//  Synchronous active-low reset returns the controller to idle and empties
//  the result register. A stalled result holds the controller; no state
//  is lost while out_tready is low.
// ----------------------------------------------------------------------------
module k_subset_unrank (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [kscu_pkg::IN_TDATA_W-1:0]   in_tdata,   // subset_size, rank
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kscu_pkg::OUT_TDATA_W-1:0]       out_tdata,  // position, element_value
  output logic                                   out_tlast,
  output logic                                   out_tuser   // error
);

  kscu_pkg::kscu_cmd_t  cmd;
  kscu_pkg::kscu_stat_t stat;

  kscu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kscu_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- dv/kscu_unrank_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscu_unrank_checker
// Watches both stream channels of k_subset_unrank. Every accepted request
// is unranked here into the colex k-subset it names. Each element the block
// returns is compared field by field with the oldest element still due.
// ----------------------------------------------------------------------------
module kscu_unrank_checker
  import kscu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   out_tuser,
  output int                     fail_count,
  output int                     pending_count,
  output int                     request_count,
  output int                     empty_count,
  output int                     result_count,
  output int                     error_count
);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element_value;
    logic              last;
    logic              error;
  } subset_elem_t;

  subset_elem_t subset_elems_due[$];
  int fails, requests, empties, results, error_results;

  assign fail_count    = fails;
  assign request_count = requests;
  assign empty_count   = empties;
  assign result_count  = results;
  assign error_count   = error_results;

  function automatic void unrank_subset(input logic [SIZE_W-1:0] size,
                                        input logic [RANK_W-1:0] rank);
    longint unsigned rem, coef, prev;
    int              pos, elem;
    bit              found;
    subset_elem_t    r;
    if (size == 0) return;
    if (size > MAX_SUBSET) begin
      r = '{position: '0, element_value: '0, last: 1'b1, error: 1'b1};
      subset_elems_due.push_back(r);
      return;
    end
    rem = (rank == 0) ? 64'd0 : 64'(rank) - 64'd1;
    for (pos = int'(size); pos >= 1; pos--) begin
      elem  = pos;
      coef  = 64'd1;
      prev  = 64'd0;
      found = 1'b0;
      while (!found && elem <= MAX_ELEMENT) begin
        if (rem < coef) begin
          found = 1'b1;
        end else begin
          elem++;
          prev = coef;
          coef = ((coef * 64'(elem)) / 64'(elem - pos)) & ((64'd1 << COEF_W) - 1);
        end
      end
      if (!found) begin
        r = '{position: POS_W'(pos - 1), element_value: '0, last: 1'b1, error: 1'b1};
        subset_elems_due.push_back(r);
        return;
      end
      rem = (rem - prev) & ((64'd1 << RANK_W) - 1);
      r = '{position: POS_W'(pos - 1), element_value: ELEM_W'(elem),
            last: (pos == 1), error: 1'b0};
      subset_elems_due.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  initial begin
    fails         = 0;
    requests      = 0;
    empties       = 0;
    results       = 0;
    error_results = 0;
  end

  always @(posedge clk) begin
    subset_elem_t want, got;
    if (!rst_n) begin
      subset_elems_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        requests++;
        if (in_tdata[SIZE_W-1:0] == 0) empties++;
        unrank_subset(in_tdata[SIZE_W-1:0], in_tdata[SIZE_W +: RANK_W]);
      end
      if (out_tvalid && out_tready) begin
        got.position      = out_tdata[POS_W-1:0];
        got.element_value = out_tdata[POS_W +: ELEM_W];
        got.last          = out_tlast;
        got.error         = out_tuser;
        results++;
        if (got.error) error_results++;
        if (subset_elems_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pos %0d elem %0d last %b err %b",
                   $time, got.position, got.element_value, got.last, got.error);
          fails++;
        end else begin
          want = subset_elems_due.pop_front();
          check_field("position", want.position, got.position);
          check_field("element_value", want.element_value, got.element_value);
          check_field("last", want.last, got.last);
          check_field("error", want.error, got.error);
        end
      end
    end
    pending_count <= subset_elems_due.size();
  end

endmodule

// ----- dv/k_subset_unrank_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_subset_unrank_tb
// Drives subset requests into k_subset_unrank with random gaps and output
// stalls, including one long output stall, and takes the verdict from the
// checker that predicts every returned element.
// ----------------------------------------------------------------------------
module k_subset_unrank_tb;
  import kscu_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  int fail_count, pending_count, request_count, empty_count, result_count, error_count;
  bit idle_on;

  localparam longint unsigned RANK_ONES = (64'd1 << RANK_W) - 1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  k_subset_unrank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  kscu_unrank_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .request_count (request_count),
    .empty_count   (empty_count),
    .result_count  (result_count),
    .error_count   (error_count)
  );

  function automatic longint unsigned colex_span(input int n, input int size);
    longint unsigned c;
    int              j;
    c = 64'd1;
    for (j = 0; j < size; j++) c = c * 64'(n - j) / 64'(j + 1);
    return c;
  endfunction

  task automatic send_request(input logic [SIZE_W-1:0] size, input longint unsigned rank);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({rank[RANK_W-1:0], size});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // result side: short random stalls, one long hold-off to back up the input
  initial begin
    int stall;
    int taken;
    out_tready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (taken == 40) stall = 400;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int              sent, sel, size, n;
    longint unsigned lim, rank;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    idle_on   = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_request(5'd0, 64'd5);
    send_request(5'd17, 64'd1);
    send_request(5'd31, RANK_ONES);
    send_request(5'd16, 64'd0);
    send_request(5'd16, 64'd1);
    send_request(5'd16, colex_span(MAX_ELEMENT, 16));
    send_request(5'd16, colex_span(MAX_ELEMENT, 16) + 1);
    send_request(5'd16, RANK_ONES);
    send_request(5'd15, colex_span(MAX_ELEMENT, 15));
    send_request(5'd1, 64'd1);
    send_request(5'd1, 64'd64);
    send_request(5'd1, 64'd65);
    send_request(5'd1, RANK_ONES);
    send_request(5'd2, colex_span(MAX_ELEMENT, 2));
    send_request(5'd2, colex_span(MAX_ELEMENT, 2) + 1);
    send_request(5'd3, 64'd0);
    send_request(5'd5, 64'd12345);
    send_request(5'd8, colex_span(MAX_ELEMENT, 8));
    send_request(5'd0, RANK_ONES);

    sent = 0;
    while (sent < 290) begin
      if (sent % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
      sel  = $urandom_range(0, 99);
      size = $urandom_range(1, MAX_SUBSET);
      rank = {$urandom, $urandom} & RANK_ONES;
      if (sel < 6) begin
        send_request(5'd0, rank);
        sent++;
        continue;
      end else if (sel < 12) begin
        size = $urandom_range(MAX_SUBSET + 1, 31);
      end else if (sel < 20) begin
        // full-width rank, mostly out of range
      end else if (sel < 25) begin
        case ($urandom_range(0, 2))
          0: rank = colex_span(MAX_ELEMENT, size);
          1: rank = colex_span(MAX_ELEMENT, size) + 1;
          default: rank = 64'd0;
        endcase
      end else begin
        n    = $urandom_range(size, MAX_ELEMENT);
        lim  = colex_span(n, size);
        rank = ({$urandom, $urandom} % lim) + 1;
      end
      send_request(SIZE_W'(size), rank);
      sent++;
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests (%0d of size zero), %0d elements checked, %0d error results.",
             request_count, empty_count, result_count, error_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never returned", fail_count, pending_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
